@@ rtl/phm_pkg.sv @@
// ----------------------------------------------------------------------------
// phm_pkg
// Shared types and constants of the pixel histogram with min and max tracking.
// ----------------------------------------------------------------------------
package phm_pkg;

  localparam int SYMBOL_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam int OP_W       = 2;
  localparam int LEN_W      = 5;
  localparam int PIX_W      = 16;
  localparam int CNT_OUT_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int IN_DATA_W  = 2 * PIX_W;
  localparam int OUT_DATA_W = 112;
  localparam int OUT_PAD_W  = OUT_DATA_W - (2 * CNT_OUT_W + 2 * PIX_W + 2 * LEN_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MASK_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BITS_STOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BITS_ALLC = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_COUNT = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    MODE_STORED = 2'd0,
    MODE_ALLOC  = 2'd1,
    MODE_HIGH   = 2'd2
  } mask_mode_e;

  // effective widths, already folded into 1..SYMBOL_BITS
  typedef struct packed {
    logic [1:0]       mode;
    logic [LEN_W-1:0] stored;
    logic [LEN_W-1:0] alloc;
  } cfg_t;

endpackage

@@ rtl/phm_queue.sv @@
// ----------------------------------------------------------------------------
// phm_queue
// Small register fifo between the classifying front and the histogram back.
// ----------------------------------------------------------------------------
module phm_queue
  import phm_pkg::*;
#(
  parameter int WIDTH = OP_W + SYMBOL_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] head_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastC  = PtrW'(QUEUE_DEPTH - 1);

  logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == DepthC);
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastC) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastC) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/phm_front.sv @@
// ----------------------------------------------------------------------------
// phm_front
// Accepts input beats, masks the sample per mask mode and queues op plus bin.
// ----------------------------------------------------------------------------
module phm_front
  import phm_pkg::*;
#(
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [IN_DATA_W-1:0]          s_tdata_i,
  input  logic [OP_W-1:0]               s_tuser_i,
  input  cfg_t                          cfg_i,
  input  logic                          q_full_i,
  input  logic                          init_busy_i,
  output logic                          push_o,
  output logic [OP_W+SYMBOL_BITS-1:0]   push_data_o
);

  logic [SYMBOL_BITS-1:0] stored_ones;
  logic [SYMBOL_BITS-1:0] alloc_ones;
  logic [SYMBOL_BITS-1:0] mask;
  logic [SYMBOL_BITS-1:0] sym;
  logic [PIX_W-1:0]       pixel;
  logic [PIX_W-1:0]       bin_index;

  assign pixel     = s_tdata_i[PIX_W-1:0];
  assign bin_index = s_tdata_i[2*PIX_W-1:PIX_W];

  always_comb begin
    for (int i = 0; i < SYMBOL_BITS; i++) begin
      stored_ones[i] = (LEN_W'(i) < cfg_i.stored);
      alloc_ones[i]  = (LEN_W'(i) < cfg_i.alloc);
    end
    case (cfg_i.mode)
      MODE_ALLOC: mask = alloc_ones;
      MODE_HIGH:  mask = alloc_ones & ~stored_ones;
      default:    mask = stored_ones;
    endcase
    // a read carries its bin index through the same slot
    if (s_tuser_i == OP_READ) begin
      sym = bin_index[SYMBOL_BITS-1:0];
    end else begin
      sym = pixel[SYMBOL_BITS-1:0] & mask;
    end
  end

  assign s_tready_o  = !q_full_i && !init_busy_i;
  assign push_o      = s_tvalid_i && s_tready_o;
  assign push_data_o = {s_tuser_i, sym};

endmodule

@@ rtl/phm_back.sv @@
// ----------------------------------------------------------------------------
// phm_back
// Bin memory read-modify-write, clear sweep, summary tracking, result register.
// ----------------------------------------------------------------------------
module phm_back
  import phm_pkg::*;
#(
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cfg_t                        cfg_i,
  input  logic                        q_empty_i,
  input  logic [OP_W+SYMBOL_BITS-1:0] q_head_i,
  output logic                        q_pop_o,
  output logic                        init_busy_o,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [OUT_DATA_W-1:0]       m_tdata_o
);

  localparam int Depth = 2 ** SYMBOL_BITS;

  typedef enum logic [2:0] {
    S_CLR  = 3'b001,
    S_IDLE = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  function automatic logic [LEN_W-1:0] sig_len(input logic [SYMBOL_BITS-1:0] v);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < SYMBOL_BITS; i++) begin
      if (v[i]) n = LEN_W'(i + 1);
    end
    return n;
  endfunction

  logic [COUNT_BITS-1:0]  mem [Depth];

  state_e                 state_q, state_d;
  logic                   init_q, init_d;
  logic [SYMBOL_BITS-1:0] clr_addr_q, clr_addr_d;
  opcode_e                op_q;
  logic [SYMBOL_BITS-1:0] addr_q;
  logic [COUNT_BITS-1:0]  rd_data_q;
  logic [COUNT_BITS-1:0]  total_q, total_d;
  logic [SYMBOL_BITS-1:0] min_q, min_d;
  logic [SYMBOL_BITS-1:0] max_q, max_d;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0]  out_data_q;
  logic [OUT_DATA_W-1:0]  out_data_d;

  logic                   out_free;
  logic                   clr_last;
  logic                   commit;
  logic                   mem_we;
  logic [SYMBOL_BITS-1:0] mem_waddr;
  logic [COUNT_BITS-1:0]  mem_wdata;
  logic [COUNT_BITS-1:0]  cnt_new;
  logic [COUNT_BITS-1:0]  bin_res;
  logic [LEN_W-1:0]       min_len;
  logic [LEN_W-1:0]       max_len;
  logic                   alert;

  assign out_free    = !out_valid_q || m_tready_i;
  assign clr_last    = (clr_addr_q == '1);
  assign q_pop_o     = (state_q == S_IDLE) && !q_empty_i;
  assign commit      = (state_q == S_EXEC) && out_free;
  assign init_busy_o = init_q;
  assign m_tvalid_o  = out_valid_q;
  assign m_tdata_o   = out_data_q;

  // saturating bin increment
  assign cnt_new = (rd_data_q == '1) ? rd_data_q : rd_data_q + 1'b1;

  always_comb begin
    total_d = total_q;
    min_d   = min_q;
    max_d   = max_q;
    bin_res = '0;
    case (op_q)
      OP_COUNT: begin
        bin_res = cnt_new;
        if (total_q != '1) total_d = total_q + 1'b1;
        if (addr_q < min_q) min_d = addr_q;
        if (addr_q > max_q) max_d = addr_q;
      end
      OP_READ: bin_res = rd_data_q;
      default: bin_res = '0;
    endcase
    min_len = sig_len(min_d);
    max_len = sig_len(max_d);
    alert   = (max_len > cfg_i.stored);
    out_data_d = {{OUT_PAD_W{1'b0}}, alert, max_len, min_len,
                  PIX_W'(max_d), PIX_W'(min_d),
                  CNT_OUT_W'(total_d), CNT_OUT_W'(bin_res)};
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = cnt_new;
    if (state_q == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else if (commit && op_q == OP_COUNT) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    clr_addr_d  = clr_addr_q;
    out_valid_d = out_valid_q && !m_tready_i;
    unique case (state_q)
      S_CLR: begin
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_last) begin
          init_d  = 1'b0;
          state_d = init_q ? S_IDLE : S_EXEC;
        end
      end
      S_IDLE: begin
        if (q_pop_o) begin
          state_d = (opcode_e'(q_head_i[OP_W+SYMBOL_BITS-1:SYMBOL_BITS]) == OP_CLEAR) ?
                    S_CLR : S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      init_q      <= 1'b1;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      min_q       <= '1;
      max_q       <= '0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
      if (state_q == S_CLR && clr_last) begin
        total_q <= '0;
        min_q   <= '1;
        max_q   <= '0;
      end else if (commit) begin
        total_q <= total_d;
        min_q   <= min_d;
        max_q   <= max_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      op_q   <= opcode_e'(q_head_i[OP_W+SYMBOL_BITS-1:SYMBOL_BITS]);
      addr_q <= q_head_i[SYMBOL_BITS-1:0];
    end
    if (commit) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (q_pop_o) begin
      rd_data_q <= mem[q_head_i[SYMBOL_BITS-1:0]];
    end
  end

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q != '0) |-> (min_q <= max_q))
    else $error("min symbol above max symbol with samples counted");

  a_no_result_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |-> !out_valid_q)
    else $error("result beat during power-up clear sweep");

  a_clear_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR && clr_last && !init_q) |=> (state_q == S_EXEC && total_q == '0))
    else $error("clear sweep did not end in a cleared result");

  a_pop_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == S_EXEC || state_q == S_CLR))
    else $error("popped op not dispatched");

endmodule

@@ rtl/pixel_histogram_min_max.sv @@
// ----------------------------------------------------------------------------
// pixel_histogram_min_max
// Pixel histogram with saturating bins, sample total and min/max symbol.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------
//  s_axis  | in  | s_tvalid_i/s_tready_o  | tuser opcode, tdata pixel, bin
//  m_axis  | out | m_tvalid_o/m_tready_i  | tdata count, total, min/max, lens
//  cfg     | in  | cfg_valid_i/cfg_ready_o| register index and write data
//
// each count, read or no-op beat passes the back end as a bin memory read,
// then the result load, with the bin write for a count; a clear writes the
// bin memory entries, one entry written per cycle, then loads a result. after
// reset a sweep zeroes the bin memory while s_tready_o stays low. a stalled
// result holds the back end; the two entry queue takes input beats until full.
// ----------------------------------------------------------------------------
module pixel_histogram_min_max
  import phm_pkg::*;
#(
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // cfg
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,   // pixel_value[15:0], bin_index[31:16]
  input  logic [OP_W-1:0]       s_tuser_i,   // opcode[1:0]
  // result stream
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  // bin_count[31:0], total_count[63:32], smallest_value[79:64],
  // largest_value[95:80], smallest_length[100:96], largest_length[105:101],
  // overlay_alert[106], zero pad[111:107]
  output logic [OUT_DATA_W-1:0] m_tdata_o
);

  localparam int QueueW = OP_W + SYMBOL_BITS;
  localparam logic [LEN_W-1:0] SymW = LEN_W'(SYMBOL_BITS);

  logic [1:0]       mask_mode_q;
  logic [LEN_W-1:0] bits_stored_q;
  logic [LEN_W-1:0] bits_alloc_q;
  cfg_t             cfg;

  logic              q_push;
  logic [QueueW-1:0] q_push_data;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  logic [QueueW-1:0] q_head;
  logic              init_busy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_mode_q   <= MODE_STORED;
      bits_stored_q <= LEN_W'(16);
      bits_alloc_q  <= LEN_W'(16);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        CFG_IDX_MASK_MODE: mask_mode_q   <= cfg_data_i[1:0];
        CFG_IDX_BITS_STOR: bits_stored_q <= cfg_data_i;
        CFG_IDX_BITS_ALLC: bits_alloc_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero or oversize widths fall back to the full symbol width
  always_comb begin
    cfg.mode   = mask_mode_q;
    cfg.stored = (bits_stored_q == '0 || bits_stored_q > SymW) ? SymW : bits_stored_q;
    cfg.alloc  = (bits_alloc_q == '0 || bits_alloc_q > SymW) ? SymW : bits_alloc_q;
  end

  phm_front #(
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_front (
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .cfg_i       (cfg),
    .q_full_i    (q_full),
    .init_busy_i (init_busy),
    .push_o      (q_push),
    .push_data_o (q_push_data)
  );

  phm_queue #(
    .WIDTH (QueueW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  phm_back #(
    .SYMBOL_BITS (SYMBOL_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .init_busy_o (init_busy),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o)
  );

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pixel histogram. A directed table covers reset
// state, width folding, every mask mode and opcode and the clear sweep. Random
// phases with fresh register settings follow. Every result beat is compared
// with a local histogram model, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb;
  import phm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 262144;
  localparam int RAND_PHASES    = 6;
  localparam int PHASE_ITEMS    = 75;
  localparam int MAX_RAND_CLEAR = 3;

  typedef struct {
    logic [31:0] bin_cnt;
    logic [31:0] total;
    logic [15:0] min_v;
    logic [15:0] max_v;
    logic [4:0]  min_len;
    logic [4:0]  max_len;
    logic        alert;
  } summary_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    opcode_e               op;
    logic [15:0]           pix;
    logic [15:0]           bin;
    logic                  typed;
    summary_t              exp;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_tvalid_i;
  logic                  s_tready_o;
  logic [IN_DATA_W-1:0]  s_tdata_i;   // pixel_value[15:0], bin_index[31:16]
  logic [OP_W-1:0]       s_tuser_i;   // opcode[1:0]
  logic                  m_tvalid_o;
  logic                  m_tready_i;
  // bin_count[31:0], total_count[63:32], smallest_value[79:64],
  // largest_value[95:80], smallest_length[100:96], largest_length[105:101],
  // overlay_alert[106], zero pad[111:107]
  logic [OUT_DATA_W-1:0] m_tdata_o;

  // local histogram copy
  logic [31:0] bin_mem [bit [15:0]];
  logic [31:0] sample_total;
  logic [15:0] min_sym;
  logic [15:0] max_sym;
  logic [1:0]  reg_mode;
  logic [4:0]  reg_stored;
  logic [4:0]  reg_alloc;

  summary_t    pending_summary_q[$];
  logic [15:0] raw_pool[$];
  logic [15:0] sym_pool[$];
  row_t        dir_rows[$];

  int errors = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;

  pixel_histogram_min_max dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // widths of 0 or above the symbol width fold to the full width
  function automatic int fold_width(input logic [4:0] w);
    if (w == 0 || w > SYMBOL_BITS_DEF) return SYMBOL_BITS_DEF;
    return int'(w);
  endfunction

  function automatic logic [15:0] ones_below(input int w);
    logic [31:0] m;
    m = (32'd1 << w) - 32'd1;
    return m[15:0];
  endfunction

  function automatic logic [4:0] bit_length(input logic [15:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) n = 5'(i + 1);
    end
    return n;
  endfunction

  task automatic histogram_step(input opcode_e op, input logic [15:0] pix,
                                input logic [15:0] bin, output summary_t r);
    int          st;
    int          al;
    logic [15:0] mask;
    logic [15:0] sym;
    st = fold_width(reg_stored);
    al = fold_width(reg_alloc);
    r.bin_cnt = '0;
    case (op)
      OP_COUNT: begin
        if (reg_mode == MODE_ALLOC) mask = ones_below(al);
        else if (reg_mode == MODE_HIGH) mask = ones_below(al) & ~ones_below(st);
        else mask = ones_below(st);
        sym = pix & mask;
        if (!bin_mem.exists(sym)) bin_mem[sym] = '0;
        if (bin_mem[sym] != 32'hffff_ffff) bin_mem[sym] = bin_mem[sym] + 1;
        r.bin_cnt = bin_mem[sym];
        if (sample_total != 32'hffff_ffff) sample_total = sample_total + 1;
        if (sym < min_sym) min_sym = sym;
        if (sym > max_sym) max_sym = sym;
        sym_pool.push_back(sym);
        if (sym_pool.size() > 32) void'(sym_pool.pop_front());
      end
      OP_READ: begin
        if (bin_mem.exists(bin)) r.bin_cnt = bin_mem[bin];
      end
      OP_CLEAR: begin
        bin_mem.delete();
        sample_total = '0;
        min_sym = 16'hffff;
        max_sym = '0;
      end
      default: ;
    endcase
    r.total   = sample_total;
    r.min_v   = min_sym;
    r.max_v   = max_sym;
    r.min_len = bit_length(min_sym);
    r.max_len = bit_length(max_sym);
    r.alert   = (int'(r.max_len) > st);
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp,
                                      input logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    summary_t e;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (pending_summary_q.size() == 0) begin
        $error("result beat with no expected result, data %0h", m_tdata_o);
        errors++;
      end else begin
        e = pending_summary_q.pop_front();
        check_field("bin_count", e.bin_cnt, m_tdata_o[31:0]);
        check_field("total_count", e.total, m_tdata_o[63:32]);
        check_field("smallest_value", 32'(e.min_v), 32'(m_tdata_o[79:64]));
        check_field("largest_value", 32'(e.max_v), 32'(m_tdata_o[95:80]));
        check_field("smallest_length", 32'(e.min_len), 32'(m_tdata_o[100:96]));
        check_field("largest_length", 32'(e.max_len), 32'(m_tdata_o[105:101]));
        check_field("overlay_alert", 32'(e.alert), 32'(m_tdata_o[106]));
        check_field("zero pad", 32'd0, 32'(m_tdata_o[111:107]));
      end
    end
  end

  // result side back-pressure in bursts
  initial begin
    m_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        m_tready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
    end
  end

  // long quiet stretches are expected during the clear sweeps
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_beat(input opcode_e op, input logic [15:0] pix,
                           input logic [15:0] bin, input logic typed,
                           input summary_t typed_exp);
    summary_t r;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {bin, pix};
    s_tuser_i  <= op;
    do @(posedge clk_i); while (!s_tready_o);
    histogram_step(op, pix, bin, r);
    pending_summary_q.push_back(typed ? typed_exp : r);
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (pending_summary_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_IDX_MASK_MODE: reg_mode   = val[1:0];
      CFG_IDX_BITS_STOR: reg_stored = val;
      CFG_IDX_BITS_ALLC: reg_alloc  = val;
      default: ;
    endcase
    // wait with valid low so back to back writes never drive valid twice per step
    @(posedge clk_i);
  endtask

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    row_t r;
    r = '{kind: ROW_CFG, idx: idx, val: val, op: OP_NOP, pix: '0, bin: '0,
          typed: 1'b0, exp: '{default: '0}};
    return r;
  endfunction

  function automatic row_t item_row(input opcode_e op, input logic [15:0] pix,
                                    input logic [15:0] bin);
    row_t r;
    r = '{kind: ROW_ITEM, idx: '0, val: '0, op: op, pix: pix, bin: bin,
          typed: 1'b0, exp: '{default: '0}};
    return r;
  endfunction

  function automatic row_t typed_row(input opcode_e op, input logic [15:0] pix,
                                     input logic [15:0] bin, input logic [31:0] bc,
                                     input logic [31:0] tot, input logic [15:0] mn,
                                     input logic [15:0] mx, input logic [4:0] mnl,
                                     input logic [4:0] mxl, input logic al);
    row_t r;
    r = item_row(op, pix, bin);
    r.typed = 1'b1;
    r.exp = '{bin_cnt: bc, total: tot, min_v: mn, max_v: mx, min_len: mnl,
              max_len: mxl, alert: al};
    return r;
  endfunction

  function automatic logic [4:0] pick_width();
    case ($urandom_range(0, 5))
      0: return 5'd1;
      1: return 5'd16;
      2: return 5'd0;
      3: return 5'd31;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  initial begin
    summary_t    none;
    opcode_e     op;
    logic [15:0] pix;
    logic [15:0] bin;
    int          pick;
    int          clears_left;

    none = '{default: '0};
    clears_left = MAX_RAND_CLEAR;
    bin_mem.delete();
    sample_total = '0;
    min_sym      = 16'hffff;
    max_sym      = '0;
    reg_mode     = MODE_STORED;
    reg_stored   = 5'd16;
    reg_alloc    = 5'd16;

    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_addr_i  <= '0;
    cfg_data_i  <= '0;
    s_tvalid_i  <= 1'b0;
    s_tdata_i   <= '0;
    s_tuser_i   <= OP_NOP;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset summary, extremes of the sample word, no-op
    dir_rows.push_back(typed_row(OP_READ, 16'h0000, 16'h0000, 0, 0, 16'hffff, 0, 16, 0, 0));
    dir_rows.push_back(typed_row(OP_NOP, 16'hffff, 16'hffff, 0, 0, 16'hffff, 0, 16, 0, 0));
    dir_rows.push_back(typed_row(OP_COUNT, 16'h0000, 16'hffff, 1, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(typed_row(OP_COUNT, 16'hffff, 16'h0000, 1, 2, 0, 16'hffff, 0, 16, 0));
    dir_rows.push_back(typed_row(OP_COUNT, 16'hffff, 16'h0000, 2, 3, 0, 16'hffff, 0, 16, 0));
    dir_rows.push_back(typed_row(OP_READ, 16'h0000, 16'hffff, 2, 3, 0, 16'hffff, 0, 16, 0));
    dir_rows.push_back(item_row(OP_COUNT, 16'h8001, 16'h5aa5));
    dir_rows.push_back(item_row(OP_READ, 16'h1234, 16'h8001));
    dir_rows.push_back(item_row(OP_NOP, 16'h0000, 16'h0000));
    // one stored bit with a wide max raises the alert
    dir_rows.push_back(cfg_row(CFG_IDX_BITS_STOR, 5'd1));
    dir_rows.push_back(item_row(OP_COUNT, 16'h0003, 16'h0000));
    dir_rows.push_back(typed_row(OP_CLEAR, 16'hffff, 16'hffff, 0, 0, 16'hffff, 0, 16, 0, 0));
    dir_rows.push_back(cfg_row(CFG_IDX_BITS_STOR, 5'd8));
    dir_rows.push_back(item_row(OP_COUNT, 16'hffff, 16'h0000));
    // upper data bits of the mode write are dropped
    dir_rows.push_back(cfg_row(CFG_IDX_MASK_MODE, 5'b10101));
    dir_rows.push_back(cfg_row(CFG_IDX_BITS_ALLC, 5'd12));
    dir_rows.push_back(item_row(OP_COUNT, 16'hffff, 16'h0000));
    dir_rows.push_back(cfg_row(CFG_IDX_MASK_MODE, 5'(MODE_HIGH)));
    dir_rows.push_back(item_row(OP_COUNT, 16'hffff, 16'h0000));
    // mode three behaves as stored bits only
    dir_rows.push_back(cfg_row(CFG_IDX_MASK_MODE, 5'd3));
    dir_rows.push_back(item_row(OP_COUNT, 16'habcd, 16'h0000));
    dir_rows.push_back(cfg_row(CFG_IDX_BITS_STOR, 5'd0));
    dir_rows.push_back(item_row(OP_COUNT, 16'hffff, 16'h0000));
    // out of range widths fold to the full width
    dir_rows.push_back(cfg_row(CFG_IDX_MASK_MODE, 5'(MODE_HIGH)));
    dir_rows.push_back(cfg_row(CFG_IDX_BITS_STOR, 5'd31));
    dir_rows.push_back(cfg_row(CFG_IDX_BITS_ALLC, 5'd0));
    dir_rows.push_back(item_row(OP_COUNT, 16'hffff, 16'h0000));
    dir_rows.push_back(cfg_row(CFG_IDX_MASK_MODE, 5'(MODE_ALLOC)));
    dir_rows.push_back(cfg_row(CFG_IDX_BITS_STOR, 5'd17));
    dir_rows.push_back(cfg_row(CFG_IDX_BITS_ALLC, 5'd1));
    dir_rows.push_back(item_row(OP_COUNT, 16'hffff, 16'h0000));
    dir_rows.push_back(item_row(OP_READ, 16'h0000, 16'h0001));
    dir_rows.push_back(item_row(OP_READ, 16'h0000, 16'hffff));
    dir_rows.push_back(typed_row(OP_CLEAR, 16'h0000, 16'h0000, 0, 0, 16'hffff, 0, 16, 0, 0));

    gap_pct   = 20;
    stall_pct = 20;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_beat(dir_rows[i].op, dir_rows[i].pix, dir_rows[i].bin,
                  dir_rows[i].typed, dir_rows[i].exp);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      write_reg(CFG_IDX_MASK_MODE, {3'($urandom_range(0, 7)), 2'($urandom_range(0, 3))});
      write_reg(CFG_IDX_BITS_STOR, pick_width());
      write_reg(CFG_IDX_BITS_ALLC, pick_width());
      if (p == RAND_PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : 10 + $urandom_range(0, 30);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 10 + $urandom_range(0, 30);
      end
      raw_pool.delete();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        pix  = 16'($urandom);
        bin  = 16'($urandom);
        if (pick < 55 || (pick == 99 && clears_left == 0)) begin
          op = OP_COUNT;
          // repeat raw words so bins climb past one
          if (raw_pool.size() != 0 && $urandom_range(0, 2) == 0)
            pix = raw_pool[$urandom_range(0, raw_pool.size() - 1)];
          raw_pool.push_back(pix);
          if (raw_pool.size() > 16) void'(raw_pool.pop_front());
        end else if (pick < 88) begin
          op = OP_READ;
          if (sym_pool.size() != 0 && $urandom_range(0, 1) == 0)
            bin = sym_pool[$urandom_range(0, sym_pool.size() - 1)];
        end else if (pick < 99) begin
          op = OP_NOP;
        end else begin
          op = OP_CLEAR;
          clears_left--;
        end
        send_beat(op, pix, bin, 1'b0, none);
      end
    end

    s_tvalid_i <= 1'b0;
    while (pending_summary_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
